[rtl/core/mbpp_pkg.sv]
// Shared types and constants for the Modbus request PDU parser.
// No dependencies; used by mbpp_step and modbus_request_pdu_parser.
`default_nettype none

package mbpp_pkg;

    typedef enum logic [2:0] {
        PH_FUNC = 3'd0,
        PH_ADDR = 3'd1,
        PH_QTY  = 3'd2,
        PH_SIZE = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_READ_BITS   = 3'd1,
        ERR_READ_REGS   = 3'd2,
        ERR_WRITE_COILS = 3'd3,
        ERR_WRITE_REGS  = 3'd4,
        ERR_REG_COUNT   = 3'd5,
        ERR_COIL_COUNT  = 3'd6,
        ERR_BAD_FUNC    = 3'd7
    } t_err;

    localparam logic [7:0] FC_READ_COILS     = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT     = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
    localparam logic [7:0] FC_WRITE_REG      = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

    localparam logic [1:0] CFG_MAX_READ_BITS   = 2'd0;
    localparam logic [1:0] CFG_MAX_READ_REGS   = 2'd1;
    localparam logic [1:0] CFG_MAX_WRITE_COILS = 2'd2;
    localparam logic [1:0] CFG_MAX_WRITE_REGS  = 2'd3;

    localparam logic [15:0] RST_MAX_READ_BITS   = 16'd2008;
    localparam logic [15:0] RST_MAX_READ_REGS   = 16'd123;
    localparam logic [15:0] RST_MAX_WRITE_COILS = 16'd2000;
    localparam logic [15:0] RST_MAX_WRITE_REGS  = 16'd120;

    typedef struct packed {
        logic [15:0] max_read_bits;
        logic [15:0] max_read_regs;
        logic [15:0] max_write_coils;
        logic [15:0] max_write_regs;
    } t_limits;

    typedef struct packed {
        t_phase      phase;
        logic        second_byte;
        logic [7:0]  func;
        logic [7:0]  high_byte;
        logic [15:0] start;
        logic [15:0] quantity;
        logic [7:0]  count;
        logic [7:0]  index;
    } t_state;

    typedef struct packed {
        logic [7:0]  func_code;
        logic [15:0] start_addr;
        logic [15:0] quantity;
        logic [7:0]  byte_count;
        logic        has_data;
        logic [7:0]  data_out;
        logic [7:0]  data_index;
        logic        last;
        t_err        error_code;
    } t_result;

    localparam t_state STATE_CLEAR = '{
        phase: PH_FUNC, second_byte: 1'b0, func: 8'd0, high_byte: 8'd0,
        start: 16'd0, quantity: 16'd0, count: 8'd0, index: 8'd0
    };

    function automatic logic is_read_bits(input logic [7:0] f);
        return (f == FC_READ_COILS) || (f == FC_READ_DISCRETE);
    endfunction

    function automatic logic is_read_regs(input logic [7:0] f);
        return (f == FC_READ_HOLDING) || (f == FC_READ_INPUT);
    endfunction

    function automatic logic is_single(input logic [7:0] f);
        return (f == FC_WRITE_COIL) || (f == FC_WRITE_REG);
    endfunction

    function automatic logic is_known(input logic [7:0] f);
        return is_read_bits(f) || is_read_regs(f) || is_single(f)
            || (f == FC_WRITE_COILS) || (f == FC_WRITE_REGS);
    endfunction

endpackage

`default_nettype wire

[rtl/core/mbpp_step.sv]
// Per-byte parsing logic: next frame state and the result an item causes.
// Purely combinational; depends on mbpp_pkg.
`default_nettype none

module mbpp_step (
    input  wire mbpp_pkg::t_state  i_state,
    input  wire mbpp_pkg::t_limits i_limits,
    input  wire logic [7:0]        i_byte,
    output mbpp_pkg::t_state       o_next,
    output logic                   o_res_valid,
    output mbpp_pkg::t_result      o_res
);

    logic [15:0] word;
    logic [16:0] need;
    logic        need_match;
    logic        data_fin;
    logic        qty_emit;
    mbpp_pkg::t_err qty_err;

    assign word = {i_state.high_byte, i_byte};

    // Required byte count: twice the register count, or coils rounded up to bytes.
    assign need = (i_state.func == mbpp_pkg::FC_WRITE_REGS)
                ? {i_state.quantity, 1'b0}
                : (({1'b0, i_state.quantity} + 17'd7) >> 3);
    assign need_match = ({9'd0, i_byte} == need);
    assign data_fin   = ({1'b0, i_state.index} + 9'd1) >= {1'b0, i_state.count};

    always_comb begin
        qty_err = mbpp_pkg::ERR_NONE;
        if (mbpp_pkg::is_read_bits(i_state.func) && word > i_limits.max_read_bits) begin
            qty_err = mbpp_pkg::ERR_READ_BITS;
        end else if (mbpp_pkg::is_read_regs(i_state.func)
                     && word > i_limits.max_read_regs) begin
            qty_err = mbpp_pkg::ERR_READ_REGS;
        end else if (i_state.func == mbpp_pkg::FC_WRITE_COILS
                     && word > i_limits.max_write_coils) begin
            qty_err = mbpp_pkg::ERR_WRITE_COILS;
        end else if (i_state.func == mbpp_pkg::FC_WRITE_REGS
                     && word > i_limits.max_write_regs) begin
            qty_err = mbpp_pkg::ERR_WRITE_REGS;
        end
    end

    assign qty_emit = (qty_err != mbpp_pkg::ERR_NONE)
                   || mbpp_pkg::is_read_bits(i_state.func)
                   || mbpp_pkg::is_read_regs(i_state.func);

    // Next state
    always_comb begin
        o_next = i_state;
        unique case (i_state.phase)
            mbpp_pkg::PH_ADDR: begin
                if (!i_state.second_byte) begin
                    o_next.high_byte   = i_byte;
                    o_next.second_byte = 1'b1;
                end else begin
                    o_next.second_byte = 1'b0;
                    o_next.start       = word;
                    if (mbpp_pkg::is_single(i_state.func)) begin
                        o_next.quantity = 16'd1;
                        o_next.count    = 8'd2;
                        o_next.index    = 8'd0;
                        o_next.phase    = mbpp_pkg::PH_DATA;
                    end else begin
                        o_next.phase = mbpp_pkg::PH_QTY;
                    end
                end
            end
            mbpp_pkg::PH_QTY: begin
                if (!i_state.second_byte) begin
                    o_next.high_byte   = i_byte;
                    o_next.second_byte = 1'b1;
                end else if (qty_emit) begin
                    o_next = mbpp_pkg::STATE_CLEAR;
                end else begin
                    o_next.second_byte = 1'b0;
                    o_next.quantity    = word;
                    o_next.index       = 8'd0;
                    o_next.phase       = mbpp_pkg::PH_SIZE;
                end
            end
            mbpp_pkg::PH_SIZE: begin
                if (!need_match || i_byte == 8'd0) begin
                    o_next = mbpp_pkg::STATE_CLEAR;
                end else begin
                    o_next.count = i_byte;
                    o_next.index = 8'd0;
                    o_next.phase = mbpp_pkg::PH_DATA;
                end
            end
            mbpp_pkg::PH_DATA: begin
                if (data_fin) begin
                    o_next = mbpp_pkg::STATE_CLEAR;
                end else begin
                    o_next.index = i_state.index + 8'd1;
                end
            end
            default: begin
                // Awaiting a function code; unused encodings land here too.
                o_next = mbpp_pkg::STATE_CLEAR;
                if (mbpp_pkg::is_known(i_byte)) begin
                    o_next.func  = i_byte;
                    o_next.phase = mbpp_pkg::PH_ADDR;
                end
            end
        endcase
    end

    // Result
    always_comb begin
        o_res_valid       = 1'b0;
        o_res.func_code   = i_state.func;
        o_res.start_addr  = i_state.start;
        o_res.quantity    = i_state.quantity;
        o_res.byte_count  = 8'd0;
        o_res.has_data    = 1'b0;
        o_res.data_out    = 8'd0;
        o_res.data_index  = 8'd0;
        o_res.last        = 1'b1;
        o_res.error_code  = mbpp_pkg::ERR_NONE;
        unique case (i_state.phase)
            mbpp_pkg::PH_ADDR: begin
                o_res_valid = 1'b0;
            end
            mbpp_pkg::PH_QTY: begin
                o_res_valid      = i_state.second_byte && qty_emit;
                o_res.quantity   = word;
                o_res.error_code = qty_err;
            end
            mbpp_pkg::PH_SIZE: begin
                o_res_valid = !need_match || i_byte == 8'd0;
                if (!need_match) begin
                    o_res.byte_count = i_byte;
                    o_res.error_code = (i_state.func == mbpp_pkg::FC_WRITE_REGS)
                                     ? mbpp_pkg::ERR_REG_COUNT
                                     : mbpp_pkg::ERR_COIL_COUNT;
                end
            end
            mbpp_pkg::PH_DATA: begin
                o_res_valid      = 1'b1;
                o_res.byte_count = i_state.count;
                o_res.has_data   = 1'b1;
                o_res.data_out   = i_byte;
                o_res.data_index = i_state.index;
                o_res.last       = data_fin;
            end
            default: begin
                // An unknown code reports itself with an otherwise cleared frame.
                o_res_valid      = !mbpp_pkg::is_known(i_byte);
                o_res.func_code  = i_byte;
                o_res.start_addr = 16'd0;
                o_res.quantity   = 16'd0;
                o_res.error_code = mbpp_pkg::ERR_BAD_FUNC;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/modbus_request_pdu_parser.sv]
// Top level of the Modbus request PDU parser: frame state, limit registers
// and the output register. Depends on mbpp_pkg and mbpp_step.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] = data_byte
//  m_axis    out        tdata = header fields and data byte, tuser = has_data,
//                       tlast = last (frame complete)
//  cfg       in         i_cfg_we, i_cfg_idx selects a limit, i_cfg_data value
//
// One byte is taken every cycle unless stalled; any result appears in the output
// register on the next cycle. The single output register sets the rate: a new
// byte is taken whenever that register is empty or being read in the same cycle.
// A stalled output holds its result and stops further bytes until it is taken.
// Reset (synchronous, active low) clears the frame state and restores the limits.
`default_nettype none

module modbus_request_pdu_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] func_code, [23:8] start_addr, [39:24] quantity, [47:40] byte_count,
    // [55:48] data_out, [63:56] data_index, [66:64] error_code, [71:67] zero
    output logic [71:0]      o_m_axis_tdata,
    output logic             o_m_axis_tuser,   // [0] has_data
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    mbpp_pkg::t_state  r_state;
    mbpp_pkg::t_state  n_state;
    mbpp_pkg::t_limits r_lim;
    mbpp_pkg::t_result r_out;
    mbpp_pkg::t_result n_out;
    logic              r_out_valid;
    logic              n_res_valid;
    logic              accept;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    mbpp_step u_step (
        .i_state     (r_state),
        .i_limits    (r_lim),
        .i_byte      (i_s_axis_tdata),
        .o_next      (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbpp_pkg::STATE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept && n_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_res_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.max_read_bits   <= mbpp_pkg::RST_MAX_READ_BITS;
            r_lim.max_read_regs   <= mbpp_pkg::RST_MAX_READ_REGS;
            r_lim.max_write_coils <= mbpp_pkg::RST_MAX_WRITE_COILS;
            r_lim.max_write_regs  <= mbpp_pkg::RST_MAX_WRITE_REGS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbpp_pkg::CFG_MAX_READ_BITS:   r_lim.max_read_bits   <= i_cfg_data;
                mbpp_pkg::CFG_MAX_READ_REGS:   r_lim.max_read_regs   <= i_cfg_data;
                mbpp_pkg::CFG_MAX_WRITE_COILS: r_lim.max_write_coils <= i_cfg_data;
                mbpp_pkg::CFG_MAX_WRITE_REGS:  r_lim.max_write_regs  <= i_cfg_data;
                default:                       r_lim                 <= r_lim;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.error_code, r_out.data_index, r_out.data_out,
                              r_out.byte_count, r_out.quantity, r_out.start_addr,
                              r_out.func_code};
    assign o_m_axis_tuser  = r_out.has_data;
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire
